// ===== rtl/vdec_pkg.sv =====
// shared constants and types for the varint decoder
`timescale 1ns / 1ps

package vdec_pkg;

  localparam int BYTE_W       = 8;
  localparam int VALUE_W      = 64;
  localparam int POS_W        = 4;
  localparam int USED_W       = 4;
  localparam int DIGIT_BITS   = 7;
  localparam int CAPPED_BYTES = 8;
  localparam int CONT_BIT     = 7;
  localparam int SHAMT_W      = 6;

  localparam logic [BYTE_W-1:0] LOW7_MASK    = BYTE_W'((1 << DIGIT_BITS) - 1);
  localparam logic [SHAMT_W-1:0] LAST_SHIFT  = SHAMT_W'(DIGIT_BITS * CAPPED_BYTES);
  localparam logic [POS_W-1:0]  LAST_POS     = POS_W'(CAPPED_BYTES);
  localparam logic [USED_W-1:0] MAX_USED     = USED_W'(CAPPED_BYTES + 1);

  // control outcome of merging one word into the accumulator
  typedef struct packed {
    logic              done;
    logic [USED_W-1:0] used;
    logic [POS_W-1:0]  pos_nxt;
  } step_ctrl_t;

endpackage

// ===== rtl/vdec_step.sv =====
// merges one encoded word into the partial value
`timescale 1ns / 1ps

module vdec_step (
  input  logic [vdec_pkg::VALUE_W-1:0] partial,
  input  logic [vdec_pkg::POS_W-1:0]   pos,
  input  logic [vdec_pkg::BYTE_W-1:0]  code_byte,
  output logic [vdec_pkg::VALUE_W-1:0] sum,
  output vdec_pkg::step_ctrl_t         ctrl
);

  logic                           ninth;
  logic [vdec_pkg::SHAMT_W-1:0]   shamt;
  logic [vdec_pkg::BYTE_W-1:0]    digit;
  logic [vdec_pkg::POS_W-1:0]     pos_inc;

  always_comb begin
    ninth   = (pos >= vdec_pkg::LAST_POS);
    pos_inc = pos + 1'b1;
    if (ninth) begin
      // ninth word: all eight bits are data
      shamt     = vdec_pkg::LAST_SHIFT;
      digit     = code_byte;
      ctrl.done = 1'b1;
      ctrl.used = vdec_pkg::MAX_USED;
    end else begin
      shamt     = vdec_pkg::SHAMT_W'(pos[2:0]) * vdec_pkg::SHAMT_W'(vdec_pkg::DIGIT_BITS);
      digit     = code_byte & vdec_pkg::LOW7_MASK;
      ctrl.done = ~code_byte[vdec_pkg::CONT_BIT];
      ctrl.used = vdec_pkg::USED_W'(pos_inc);
    end
    sum          = partial + (vdec_pkg::VALUE_W'(digit) << shamt);
    ctrl.pos_nxt = ctrl.done ? '0 : pos_inc;
  end

endmodule

// ===== rtl/varint_decode_u64.sv =====
// top level of the streaming base-128 varint decoder
`timescale 1ns / 1ps

// varint_decode_u64: decodes little-endian base-128 integers of up to 64 bits
// - input channel: one encoded word per handshake on in_code_byte
// - words one to eight carry seven data bits, bit 7 set means more follow
// - after eight continued words a ninth word adds all eight bits at shift 56
// - result channel: out_decoded_value with out_bytes_used (1 to 9), one
//   result per completed integer, none for words that continue
// - a word accepted on the input lands in the input register; a word that
//   completes an integer moves its result into the output register when that
//   register is free or being taken, and out_valid rises with the load
// - throughput: one word per cycle unless a stalled result blocks a last word;
//   only a masked shift and 64-bit add sit between input and output registers
// - the output register frees up in the same cycle it is taken, so a
//   continuous stream with out_ready held high never stalls
// - when the receiver stalls, the result waits in the output register, the
//   word behind it waits in the input register and in_ready drops
// - words that yield no result keep flowing while a result is waiting
// - reset (rst_n low, synchronous) empties both registers and clears the
//   accumulator and byte position; no clearing pass is needed
module varint_decode_u64 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vdec_pkg::BYTE_W-1:0]   in_code_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vdec_pkg::VALUE_W-1:0]  out_decoded_value,
  output logic [vdec_pkg::USED_W-1:0]   out_bytes_used
);

  // input register
  logic                         in_valid_r;
  logic [vdec_pkg::BYTE_W-1:0]  in_byte_r;

  // decoder state
  logic [vdec_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [vdec_pkg::POS_W-1:0]   pos_r, pos_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [vdec_pkg::VALUE_W-1:0] out_value_r;
  logic [vdec_pkg::USED_W-1:0]  out_used_r;

  logic [vdec_pkg::VALUE_W-1:0] sum;
  vdec_pkg::step_ctrl_t         ctrl;
  logic                         advance;
  logic                         emit;

  vdec_step u_step (
    .partial   (acc_r),
    .pos       (pos_r),
    .code_byte (in_byte_r),
    .sum       (sum),
    .ctrl      (ctrl)
  );

  // a continuing word never needs the output register
  assign advance  = in_valid_r && (!ctrl.done || !out_valid_r || out_ready);
  assign emit     = advance && ctrl.done;
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (advance) begin
      acc_nxt = ctrl.done ? '0 : sum;
      pos_nxt = ctrl.pos_nxt;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      pos_r       <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_code_byte;
    end
    if (emit) begin
      out_value_r <= sum;
      out_used_r  <= ctrl.used;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decoded_value = out_value_r;
  assign out_bytes_used    = out_used_r;

  // byte position never passes the ninth-word slot
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= vdec_pkg::LAST_POS)
    else $error("byte position out of range");

  // a fresh integer starts from an empty accumulator
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == '0 |-> acc_r == '0)
    else $error("accumulator not clear at start of integer");

  // every completed integer restarts the decoder
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (pos_r == '0 && acc_r == '0 && out_valid_r))
    else $error("decoder did not restart after a result");

  // a held result reports a legal word count
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_used_r >= 1 && out_used_r <= vdec_pkg::MAX_USED))
    else $error("bytes used out of range");

  // a waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("result overwritten while stalled");

endmodule

// ===== sim/varint_decode_u64_chk.sv =====
// checker for the varint decoder: predicts decoded integers and compares results
`timescale 1ns / 1ps

module varint_decode_u64_chk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [vdec_pkg::BYTE_W-1:0]  in_code_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [vdec_pkg::VALUE_W-1:0] out_decoded_value,
  input  logic [vdec_pkg::USED_W-1:0]  out_bytes_used,
  output int                           mismatch_count,
  output int                           pending_results
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [vdec_pkg::VALUE_W-1:0] value;
    logic [vdec_pkg::USED_W-1:0]  used;
  } varint_t;

  varint_t                      expected_ints[$];
  logic [vdec_pkg::VALUE_W-1:0] decode_acc = '0;
  logic [vdec_pkg::POS_W-1:0]   decode_pos = '0;
  int                           errors = 0;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin : watch
    varint_t                     want;
    logic [vdec_pkg::BYTE_W-1:0] w;
    logic                        complete;
    if (!rst_n) begin
      decode_acc = '0;
      decode_pos = '0;
      expected_ints.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ints.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("unexpected result: value %h used %0d",
                     out_decoded_value, out_bytes_used);
          errors++;
        end else begin
          want = expected_ints.pop_front();
          if (out_decoded_value !== want.value || out_bytes_used !== want.used) begin
            if (errors < REPORT_LIMIT)
              $display("mismatch: value exp %h got %h, bytes used exp %0d got %0d",
                       want.value, out_decoded_value, want.used, out_bytes_used);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        w        = in_code_byte;
        complete = 1'b0;
        if (decode_pos >= vdec_pkg::LAST_POS) begin
          // ninth word: all eight bits are data
          want.value = decode_acc
                       + (vdec_pkg::VALUE_W'(w) << vdec_pkg::LAST_SHIFT);
          want.used  = vdec_pkg::MAX_USED;
          complete   = 1'b1;
        end else begin
          decode_acc = decode_acc
                       + (vdec_pkg::VALUE_W'(w & vdec_pkg::LOW7_MASK)
                          << (vdec_pkg::DIGIT_BITS * decode_pos));
          decode_pos = decode_pos + 1'b1;
          if (!w[vdec_pkg::CONT_BIT]) begin
            want.value = decode_acc;
            want.used  = vdec_pkg::USED_W'(decode_pos);
            complete   = 1'b1;
          end
        end
        if (complete) begin
          expected_ints.push_back(want);
          decode_acc = '0;
          decode_pos = '0;
        end
      end
    end
    pending_results <= expected_ints.size();
    mismatch_count  <= errors;
  end

endmodule

// ===== sim/tb_varint_decode_u64.sv =====
// testbench top for the varint decoder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_varint_decode_u64;

  // random words after the directed part
  localparam int N_RANDOM       = 1900;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLDOFF_CYCLES = 300;
  localparam int HOLDOFF_AFTER  = 600;
  // result follows its last word through both registers; leave some slack
  localparam int DRAIN_CYCLES   = 8;
  // watchdog bound on the whole run, very generous
  localparam int CYCLE_LIMIT    = 400000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [vdec_pkg::BYTE_W-1:0]  in_code_byte = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [vdec_pkg::VALUE_W-1:0] out_decoded_value;
  logic [vdec_pkg::USED_W-1:0]  out_bytes_used;

  int mismatch_count;
  int pending_results;

  // words handed over so far, watched by the receiver to time the hold-off
  int words_sent = 0;
  int cycle_count = 0;

  logic [vdec_pkg::BYTE_W-1:0] code_words[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  varint_decode_u64 DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_code_byte      (in_code_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_value (out_decoded_value),
    .out_bytes_used    (out_bytes_used)
  );

  varint_decode_u64_chk chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_code_byte      (in_code_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_value (out_decoded_value),
    .out_bytes_used    (out_bytes_used),
    .mismatch_count    (mismatch_count),
    .pending_results   (pending_results)
  );

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("varint_decode_u64 test failed");
      $finish;
    end
  end

  // receiver: phases of always-ready, a repeating stall pattern or coin flips,
  // plus one long hold-off once the sender is well into the stream
  initial begin : receiver
    int          mode;
    int          span;
    int          ph;
    int          hold_cycle;
    logic [15:0] pattern;
    bit          holdoff_done;
    holdoff_done = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      // keep at least one ready slot per pattern so stalls stay bounded
      pattern = 16'($urandom) | 16'h0001;
      span    = $urandom_range(16, 160);
      for (ph = 0; ph < span; ph++) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= pattern[ph % 16];
          2: out_ready <= ($urandom_range(0, 2) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if (!holdoff_done && words_sent > HOLDOFF_AFTER) begin
        // sender keeps offering words, so the output and input registers fill
        for (hold_cycle = 0; hold_cycle < HOLDOFF_CYCLES; hold_cycle++) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
        holdoff_done = 1'b1;
      end
    end
  end

  initial begin : sender
    int                          idx;
    int                          burst;
    int                          gap;
    int                          nbytes;
    int                          k;
    int                          r;
    logic [vdec_pkg::BYTE_W-1:0] w;

    // directed words: smallest and largest one-word values, a two-word value,
    // the all-ones nine-word value and a nine-word value whose last word
    // carries bit 7 as data
    code_words.push_back(8'h00);
    code_words.push_back(8'h7f);
    code_words.push_back(8'h80);
    code_words.push_back(8'h01);
    repeat (9) code_words.push_back(8'hff);
    repeat (9) code_words.push_back(8'h80);

    // random part: mostly well-formed integers of every length with random
    // digits; about one in ten picks is a run of raw words instead
    while (code_words.size() < N_RANDOM + 22) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 4)) code_words.push_back(vdec_pkg::BYTE_W'($urandom));
      end else begin
        // long integers get a little extra weight so the ninth word is common
        nbytes = (r >= 8) ? $urandom_range(8, 9) : $urandom_range(1, 9);
        for (k = 0; k < nbytes; k++) begin
          w = vdec_pkg::BYTE_W'($urandom);
          if (k == vdec_pkg::CAPPED_BYTES) begin
            // ninth word goes in raw
          end else if (k == nbytes - 1) begin
            w[vdec_pkg::CONT_BIT] = 1'b0;
          end else begin
            w[vdec_pkg::CONT_BIT] = 1'b1;
          end
          code_words.push_back(w);
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // bursts of back-to-back words separated by random gaps
    idx = 0;
    while (idx < code_words.size()) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && idx < code_words.size(); k++) begin
        in_valid     <= 1'b1;
        in_code_byte <= code_words[idx];
        do @(posedge clk); while (!in_ready);
        idx++;
        words_sent = idx;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid     <= 1'b0;
        in_code_byte <= vdec_pkg::BYTE_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // let the checker count the last accepted word before draining
    @(posedge clk);
    // drain: every expected integer must come out, then a few quiet cycles
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("varint_decode_u64 test passed");
    end else begin
      $display("varint_decode_u64 test failed");
    end
    $finish;
  end

endmodule
